### rtl/cra_pkg.sv
// shared types, widths and helpers for the convergence relax adjuster
package cra_pkg;

	localparam int HIST_DEPTH = 20;
	localparam int NUM_LANES  = 4;
	localparam int K_W        = 5;
	localparam int VAL_W      = 32;
	localparam int FIX_W      = 48;
	localparam int REF_W      = 31;
	localparam int CFG_W      = 48;
	localparam int IDX_W      = 2;
	localparam int CNT_W      = 4;
	localparam int SUM_W      = 38;
	localparam int DEV_W      = 42;
	localparam int CMP_W      = 56;
	localparam int PROD_W     = 52;
	localparam int DIG_STEPS  = PROD_W / 4;

	localparam logic [K_W-1:0]   K_LAST   = K_W'(HIST_DEPTH - 1);
	localparam logic [K_W-1:0]   K_W15    = K_W'(15);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(15);
	localparam logic [CNT_W-1:0] CNT_RUN  = CNT_W'(10);

	localparam logic [IDX_W-1:0] REG_DISP_REF   = 2'd0;
	localparam logic [IDX_W-1:0] REG_STEP_UPPER = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEP_LOWER = 2'd2;

	localparam logic [REF_W-1:0] DISP_REF_RST   = REF_W'(65536);
	localparam logic [FIX_W-1:0] STEP_UPPER_RST = {FIX_W{1'b1}};
	localparam logic [FIX_W-1:0] STEP_LOWER_RST = FIX_W'(1677722);

	typedef enum logic {
		OP_RAISE = 1'b0,
		OP_LOWER = 1'b1
	} scale_op_t;

	typedef struct packed {
		logic           shift;
		logic           clr;
		logic           sum_en;
		logic           dev_en;
		logic [K_W-1:0] k;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] s20;
		logic signed [SUM_W-1:0] s15;
		logic signed [SUM_W-1:0] s10;
		logic [DEV_W-1:0]        d20;
		logic [DEV_W-1:0]        d15;
		logic [DEV_W-1:0]        d10;
	} lane_res_t;

	typedef struct packed {
		logic [2:0] raise;
		logic       lower;
	} adj_flags_t;

	function automatic logic [DEV_W-1:0] dev_mag(input logic signed [SUM_W-1:0] d);
		logic signed [SUM_W-1:0] n;
		n = d[SUM_W-1] ? -d : d;
		return DEV_W'($unsigned(n));
	endfunction

	function automatic logic [CMP_W-1:0] cmp_mag(input logic signed [CMP_W-1:0] d);
		logic signed [CMP_W-1:0] n;
		n = d[CMP_W-1] ? -d : d;
		return $unsigned(n);
	endfunction

endpackage

### rtl/convergence_relax_adjuster_top.sv
// top level: configuration, item sequencing, lanes, merge and relax scaling
//
// One transaction in gives one transaction out. For the first ten items relax passes
// straight through S_FIN into the output register. From the eleventh item on, the four
// lanes walk their 20-entry histories twice (first the sums, then the absolute
// deviations), the merge registers its flags in S_DECIDE, the four scaling choices are
// tried in turn in S_PICK, and each applied scaling runs through the nibble-serial
// divide-by-ten unit before S_FIN hands the result on. Items are taken one at a time;
// the output register lets the next item start while a result waits.
module convergence_relax_adjuster_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cra_pkg::IDX_W-1:0]         cfg_idx,
	input  logic [cra_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [cra_pkg::VAL_W-1:0]  max_force,
	input  logic signed [cra_pkg::VAL_W-1:0]  max_disp,
	input  logic signed [cra_pkg::VAL_W-1:0]  mean_force,
	input  logic signed [cra_pkg::VAL_W-1:0]  mean_disp,
	input  logic [cra_pkg::FIX_W-1:0]         time_step,
	input  logic [cra_pkg::FIX_W-1:0]         relax_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cra_pkg::FIX_W-1:0]         relax_out,
	output logic [1:0]                        raise_count,
	output logic                              lowered
);
	import cra_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SUM    = 7'b0000010,
		S_DEV    = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_PICK   = 7'b0010000,
		S_WAIT   = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t state_q;
	logic [REF_W-1:0] disp_ref_q;
	logic [FIX_W-1:0] step_upper_q, step_lower_q, step_q, relax_q;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [K_W-1:0]   k_q;
	logic [1:0]       op_q;
	logic             run_q, accept;

	logic [FIX_W-1:0] relax_out_q;
	logic [1:0]       raise_out_q;
	logic             lowered_q, out_valid_q;

	lane_ctl_t  ctl;
	lane_res_t  lanes [NUM_LANES];
	logic signed [VAL_W-1:0] lane_din [NUM_LANES];
	adj_flags_t flags;
	logic [3:0] flag_vec;
	logic       sc_start, sc_done;
	logic [FIX_W-1:0] sc_out;
	scale_op_t  sc_op;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign count_nx = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;

	assign lane_din[0] = max_force;
	assign lane_din[1] = max_disp;
	assign lane_din[2] = mean_force;
	assign lane_din[3] = mean_disp;

	assign ctl.shift  = accept;
	assign ctl.clr    = accept;
	assign ctl.sum_en = (state_q == S_SUM);
	assign ctl.dev_en = (state_q == S_DEV);
	assign ctl.k      = k_q;

	for (genvar v = 0; v < NUM_LANES; v++) begin : g_lane
		cra_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    (lane_din[v]),
			.res    (lanes[v])
		);
	end

	cra_merge u_merge (
		.clk         (clk),
		.load        (state_q == S_DECIDE),
		.lanes       (lanes),
		.disp_ref    (disp_ref_q),
		.below_upper (step_q < step_upper_q),
		.above_lower (step_q > step_lower_q),
		.flags       (flags)
	);

	assign flag_vec = {flags.lower, flags.raise};
	assign sc_start = (state_q == S_PICK) && flag_vec[op_q];
	assign sc_op    = (op_q == 2'd3) ? OP_LOWER : OP_RAISE;

	cra_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.op     (sc_op),
		.r_in   (relax_q),
		.done   (sc_done),
		.r_out  (sc_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_ref_q   <= DISP_REF_RST;
			step_upper_q <= STEP_UPPER_RST;
			step_lower_q <= STEP_LOWER_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DISP_REF:   disp_ref_q   <= cfg_data[REF_W-1:0];
				REG_STEP_UPPER: step_upper_q <= cfg_data[FIX_W-1:0];
				REG_STEP_LOWER: step_lower_q <= cfg_data[FIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			op_q        <= '0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_nx;
						k_q     <= '0;
						run_q   <= count_nx > CNT_RUN;
						state_q <= (count_nx > CNT_RUN) ? S_SUM : S_FIN;
					end
				end
				S_SUM: begin
					k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
					if (k_q == K_LAST) state_q <= S_DEV;
				end
				S_DEV: begin
					k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
					if (k_q == K_LAST) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					op_q    <= '0;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (flag_vec[op_q]) begin
						state_q <= S_WAIT;
					end else if (op_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						op_q <= op_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (sc_done) begin
						if (op_q == 2'd3) begin
							state_q <= S_FIN;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_PICK;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_q  <= time_step;
			relax_q <= relax_in;
		end else if (state_q == S_WAIT && sc_done) begin
			relax_q <= sc_out;
		end
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			relax_out_q <= relax_q;
			raise_out_q <= run_q ? 2'({1'b0, flags.raise[0]} + {1'b0, flags.raise[1]}
				+ {1'b0, flags.raise[2]}) : 2'd0;
			lowered_q   <= run_q & flags.lower;
		end
	end

	assign out_valid   = out_valid_q;
	assign relax_out   = relax_out_q;
	assign raise_count = raise_out_q;
	assign lowered     = lowered_q;

endmodule

### rtl/cra_lane.sv
// one monitored value: history shift line and windowed sum and deviation accumulators
module cra_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cra_pkg::lane_ctl_t            ctl,
	input  logic signed [cra_pkg::VAL_W-1:0] din,
	output cra_pkg::lane_res_t            res
);
	import cra_pkg::*;

	logic signed [VAL_W-1:0] hist_q [HIST_DEPTH];
	logic signed [SUM_W-1:0] s20_q, s15_q, s10_q;
	logic [DEV_W-1:0]        d20_q, d15_q, d10_q;

	logic signed [VAL_W-1:0] x;
	logic signed [SUM_W-1:0] xs, x20, x15, x10;
	logic                    in15, even;

	assign x    = hist_q[ctl.k];
	assign xs   = SUM_W'(x);
	assign x20  = (xs <<< 4) + (xs <<< 2);
	assign x15  = (xs <<< 4) - xs;
	assign x10  = (xs <<< 3) + (xs <<< 1);
	assign in15 = ctl.k < K_W15;
	assign even = ~ctl.k[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
		end else if (ctl.shift) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
			hist_q[0] <= din;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			s20_q <= '0;
			s15_q <= '0;
			s10_q <= '0;
			d20_q <= '0;
			d15_q <= '0;
			d10_q <= '0;
		end else if (ctl.sum_en) begin
			s20_q <= s20_q + xs;
			if (in15) s15_q <= s15_q + xs;
			if (even) s10_q <= s10_q + xs;
		end else if (ctl.dev_en) begin
			d20_q <= d20_q + dev_mag(x20 - s20_q);
			if (in15) d15_q <= d15_q + dev_mag(x15 - s15_q);
			if (even) d10_q <= d10_q + dev_mag(x10 - s10_q);
		end
	end

	assign res.s20 = s20_q;
	assign res.s15 = s15_q;
	assign res.s10 = s10_q;
	assign res.d20 = d20_q;
	assign res.d15 = d15_q;
	assign res.d10 = d10_q;

endmodule

### rtl/cra_merge.sv
// merging stage: oscillation, variation, displacement, slowness and stability tests over the lane results
module cra_merge (
	input  logic                        clk,
	input  logic                        load,
	input  cra_pkg::lane_res_t          lanes [cra_pkg::NUM_LANES],
	input  logic [cra_pkg::REF_W-1:0]   disp_ref,
	input  logic                        below_upper,
	input  logic                        above_lower,
	output cra_pkg::adj_flags_t         flags
);
	import cra_pkg::*;

	adj_flags_t flags_q;
	logic [CMP_W-1:0]        ref_c, m_osc, m_s15, d10, d15, d20;
	logic signed [CMP_W-1:0] osc, slow_lhs;
	logic [NUM_LANES-1:0]    stable;
	logic                    t_osc, t_var, t_big, t_slow;

	always_comb begin
		for (int v = 0; v < NUM_LANES; v++) begin
			stable[v] = cmp_mag(CMP_W'(lanes[v].s20)) * CMP_W'(5) > CMP_W'(lanes[v].d20);
		end
	end

	assign ref_c    = CMP_W'(disp_ref);
	assign d10      = CMP_W'(lanes[1].d10);
	assign d15      = CMP_W'(lanes[1].d15);
	assign d20      = CMP_W'(lanes[1].d20);
	assign osc      = CMP_W'(lanes[1].s20) - (CMP_W'(lanes[1].s10) <<< 1);
	assign m_osc    = cmp_mag(osc);
	assign m_s15    = cmp_mag(CMP_W'(lanes[1].s15));
	assign slow_lhs = $signed(ref_c * CMP_W'(400))
		- $signed(cmp_mag(CMP_W'(lanes[1].s20)) * CMP_W'(20));

	assign t_osc  = m_osc * CMP_W'(10) > (d10 << 2);
	assign t_var  = m_s15 * CMP_W'(60) < d15;
	assign t_big  = (d15 << 1) > ref_c * CMP_W'(225);
	assign t_slow = slow_lhs > $signed(d20);

	always_ff @(posedge clk) begin
		if (load) begin
			flags_q.raise <= {t_big, t_var, t_osc} & {3{below_upper}};
			flags_q.lower <= stable[0] & t_slow & stable[2] & stable[3] & above_lower;
		end
	end

	assign flags = flags_q;

endmodule

### rtl/cra_scale.sv
// relax scaling by 11/10 (saturating) or 9/10, dividing by ten one nibble per cycle
module cra_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  cra_pkg::scale_op_t          op,
	input  logic [cra_pkg::FIX_W-1:0]   r_in,
	output logic                        done,
	output logic [cra_pkg::FIX_W-1:0]   r_out
);
	import cra_pkg::*;

	localparam int STEP_W = $clog2(DIG_STEPS);

	logic                  busy_q, done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [PROD_W-1:0]     p_q, q_q, prod;
	logic [3:0]            rem_q, qd, rem_d;
	logic [7:0]            part;
	logic [15:0]           recip;

	assign prod = (op == OP_RAISE)
		? (PROD_W'(r_in) << 3) + (PROD_W'(r_in) << 1) + PROD_W'(r_in)
		: (PROD_W'(r_in) << 3) + PROD_W'(r_in);

	// partial remainder stays below 160, so x*205>>11 gives the exact digit
	assign part  = {rem_q, p_q[PROD_W-1 -: 4]};
	assign recip = 16'(part) * 16'd205;
	assign qd    = recip[14:11];
	assign rem_d = 4'(part - 8'(qd) * 8'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIG_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= prod;
			q_q   <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			p_q   <= p_q << 4;
			q_q   <= {q_q[PROD_W-5:0], qd};
			rem_q <= rem_d;
		end
	end

	assign done  = done_q;
	assign r_out = (|q_q[PROD_W-1:FIX_W]) ? {FIX_W{1'b1}} : q_q[FIX_W-1:0];

endmodule
